[src/fcpm_pkg.sv]
package fcpm_pkg;

  localparam int unsigned MAX_CH = 4;
  localparam int unsigned NUM_CHANNELS = 4;
  localparam int unsigned HEADER_BYTES = 44;

  localparam logic [7:0] SILENCE_LEVEL = 8'h80;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STOP = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [3:0] REG_BASE_ADDR_CH0 = 4'd0;
  localparam logic [3:0] REG_FILE_LEN_CH0 = 4'd4;

  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned CFG_DATA_W = 21;
  localparam int unsigned BASE_W = 21;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned ADDR_W = 22;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] channel;
    logic [7:0] sample_ch0;
    logic [7:0] sample_ch1;
    logic [7:0] sample_ch2;
    logic [7:0] sample_ch3;
  } in_t;

  typedef struct packed {
    logic [7:0]        mixed_sample;
    logic              sample_valid;
    logic [MAX_CH-1:0] active_mask;
    logic [ADDR_W-1:0] read_addr_ch0;
    logic [ADDR_W-1:0] read_addr_ch1;
    logic [ADDR_W-1:0] read_addr_ch2;
    logic [ADDR_W-1:0] read_addr_ch3;
  } out_t;

  typedef struct packed {
    logic start;
    logic stop;
    logic tick;
  } lane_ctl_t;

  typedef struct packed {
    logic              playing;
    logic signed [7:0] smp;
    logic [ADDR_W-1:0] addr;
  } lane_sts_t;

  function automatic logic [BASE_W-1:0] base_rst(input int unsigned c);
    logic [BASE_W-1:0] v;
    case (c)
      0: v = 21'h10000;
      1: v = 21'h20000;
      2: v = 21'h30000;
      default: v = 21'h40000;
    endcase
    return v;
  endfunction

  function automatic logic [LEN_W-1:0] len_rst(input int unsigned c);
    logic [LEN_W-1:0] v;
    case (c)
      0: v = 16'd14862;
      1: v = 16'd11598;
      2: v = 16'd7174;
      default: v = 16'd23132;
    endcase
    return v;
  endfunction

endpackage

[src/four_channel_pcm_playback_mixer.sv]
// Four-channel PCM playback mixer. Each input transfer is a start, stop or tick command;
// every accepted item yields exactly one result transfer holding the mixed byte (128 when
// no channel plays or the item is not a tick), the playing flags after the step and the next
// fetch address of each channel. From acceptance an item passes the per-channel lane update
// register and the register for the lane sum and active count, then the divide by that count
// (shifts or a reciprocal multiply) feeds the result register, loaded once the output is free.
// A new item is accepted once the previous one has left the divide stage, so the block
// takes no new item while one is in flight. Configuration writes are always ready and
// must only be issued while no item is in flight.
module four_channel_pcm_playback_mixer #(
  parameter int unsigned NUM_CHANNELS = fcpm_pkg::NUM_CHANNELS,
  parameter int unsigned HEADER_BYTES = fcpm_pkg::HEADER_BYTES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  fcpm_pkg::in_t                    in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output fcpm_pkg::out_t                   out_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [fcpm_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [fcpm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV
  } state_e;

  state_e              state_q;
  logic                in_fire, out_free, tick_q, out_valid_q;
  fcpm_pkg::out_t      out_q;
  fcpm_pkg::lane_sts_t sts [fcpm_pkg::MAX_CH];
  logic [7:0]          samples [fcpm_pkg::MAX_CH];
  logic [7:0]          mixed;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  assign samples[0] = in_i.sample_ch0;
  assign samples[1] = in_i.sample_ch1;
  assign samples[2] = in_i.sample_ch2;
  assign samples[3] = in_i.sample_ch3;

  for (genvar c = 0; c < fcpm_pkg::MAX_CH; c++) begin : g_lane
    if (c < NUM_CHANNELS) begin : g_on
      fcpm_pkg::lane_ctl_t ctl;
      logic                hit;

      assign hit       = in_fire && (in_i.channel == 2'(c));
      assign ctl.start = hit && (in_i.cmd == fcpm_pkg::CMD_START);
      assign ctl.stop  = hit && (in_i.cmd == fcpm_pkg::CMD_STOP);
      assign ctl.tick  = in_fire && (in_i.cmd == fcpm_pkg::CMD_TICK);

      fcpm_lane #(
        .Chan        (c),
        .HeaderBytes (HEADER_BYTES)
      ) u_lane (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctl_i       (ctl),
        .sample_i    (samples[c]),
        .cfg_we_i    (cfg_valid_i),
        .cfg_index_i (cfg_index_i),
        .cfg_data_i  (cfg_data_i),
        .sts_o       (sts[c])
      );
    end else begin : g_off
      assign sts[c] = '0;
    end
  end

  fcpm_mix #(
    .NumChannels (NUM_CHANNELS)
  ) u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (state_q == ST_SUM),
    .sts_i   (sts),
    .mixed_o (mixed)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != ST_DIV) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            tick_q  <= (in_i.cmd == fcpm_pkg::CMD_TICK);
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (out_free) begin
            out_q.mixed_sample  <= tick_q ? mixed : fcpm_pkg::SILENCE_LEVEL;
            out_q.sample_valid  <= tick_q;
            out_q.active_mask   <= {sts[3].playing, sts[2].playing,
                                    sts[1].playing, sts[0].playing};
            out_q.read_addr_ch0 <= sts[0].addr;
            out_q.read_addr_ch1 <= sts[1].addr;
            out_q.read_addr_ch2 <= sts[2].addr;
            out_q.read_addr_ch3 <= sts[3].addr;
            out_valid_q         <= 1'b1;
            state_q             <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

[src/fcpm_lane.sv]
module fcpm_lane #(
  parameter int unsigned Chan = 0,
  parameter int unsigned HeaderBytes = fcpm_pkg::HEADER_BYTES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fcpm_pkg::lane_ctl_t               ctl_i,
  input  logic [7:0]                        sample_i,
  input  logic                              cfg_we_i,
  input  logic [fcpm_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [fcpm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output fcpm_pkg::lane_sts_t               sts_o
);

  localparam logic [fcpm_pkg::LEN_W-1:0] Hdr = fcpm_pkg::LEN_W'(HeaderBytes);
  localparam logic [fcpm_pkg::CFG_INDEX_W-1:0] BaseIdx =
    fcpm_pkg::REG_BASE_ADDR_CH0 + fcpm_pkg::CFG_INDEX_W'(Chan);
  localparam logic [fcpm_pkg::CFG_INDEX_W-1:0] LenIdx =
    fcpm_pkg::REG_FILE_LEN_CH0 + fcpm_pkg::CFG_INDEX_W'(Chan);

  logic [fcpm_pkg::BASE_W-1:0] base_q;
  logic [fcpm_pkg::LEN_W-1:0]  len_q;
  logic [fcpm_pkg::LEN_W-1:0]  off_q, off_d, off_inc, clip_len;
  logic                        play_q, play_d;
  logic signed [7:0]           smp_q;

  assign clip_len = (len_q <= Hdr) ? fcpm_pkg::LEN_W'(1) : len_q - Hdr;
  assign off_inc  = off_q + fcpm_pkg::LEN_W'(1);

  always_comb begin
    off_d  = off_q;
    play_d = play_q;
    if (ctl_i.start || ctl_i.stop) begin
      off_d  = '0;
      play_d = ctl_i.start;
    end else if (ctl_i.tick && play_q) begin
      off_d = off_inc;
      if (off_inc >= clip_len) begin
        play_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= fcpm_pkg::base_rst(Chan);
      len_q  <= fcpm_pkg::len_rst(Chan);
      off_q  <= '0;
      play_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == BaseIdx) begin
        base_q <= cfg_data_i[fcpm_pkg::BASE_W-1:0];
      end
      if (cfg_we_i && cfg_index_i == LenIdx) begin
        len_q <= cfg_data_i[fcpm_pkg::LEN_W-1:0];
      end
      off_q  <= off_d;
      play_q <= play_d;
    end
  end

  // sample minus 128 as a signed byte
  always_ff @(posedge clk_i) begin
    if (ctl_i.tick) begin
      smp_q <= signed'({~sample_i[7], sample_i[6:0]});
    end
  end

  assign sts_o.playing = play_q;
  assign sts_o.smp     = play_q ? smp_q : 8'sd0;
  assign sts_o.addr    = fcpm_pkg::ADDR_W'(base_q) + fcpm_pkg::ADDR_W'(HeaderBytes)
                       + fcpm_pkg::ADDR_W'(off_q);

endmodule

[src/fcpm_mix.sv]
module fcpm_mix #(
  parameter int unsigned NumChannels = fcpm_pkg::NUM_CHANNELS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  fcpm_pkg::lane_sts_t sts_i [fcpm_pkg::MAX_CH],
  output logic [7:0]          mixed_o
);

  localparam int unsigned SumW = 10;
  localparam int unsigned ProdW = 20;
  localparam logic [ProdW-1:0] Recip3 = ProdW'(683);
  localparam int unsigned Recip3Shift = 11;

  logic signed [SumW-1:0] sum_d, sum_q;
  logic [2:0]             cnt_d, cnt_q;
  logic [SumW-1:0]        mag, quo, quo_s;
  logic [ProdW-1:0]       prod;

  always_comb begin
    sum_d = '0;
    cnt_d = '0;
    for (int c = 0; c < fcpm_pkg::MAX_CH; c++) begin
      if (c < NumChannels) begin
        sum_d = sum_d + SumW'(sts_i[c].smp);
        cnt_d = cnt_d + 3'(sts_i[c].playing);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (load_i) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  // truncating divide by the 1..4 active count, on the magnitude
  assign mag  = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign prod = ProdW'(mag) * Recip3;

  always_comb begin
    case (cnt_q)
      3'd1:    quo = mag;
      3'd2:    quo = mag >> 1;
      3'd3:    quo = prod[Recip3Shift +: SumW];
      default: quo = mag >> 2;
    endcase
    quo_s = sum_q[SumW-1] ? SumW'(-quo) : quo;
    if (cnt_q == 3'd0) begin
      mixed_o = fcpm_pkg::SILENCE_LEVEL;
    end else begin
      mixed_o = quo_s[7:0] ^ fcpm_pkg::SILENCE_LEVEL;
    end
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam logic [fcpm_pkg::CFG_INDEX_W-1:0] REG_SPARE_FIRST =
    fcpm_pkg::REG_FILE_LEN_CH0 + 4'(fcpm_pkg::MAX_CH);
  localparam logic [fcpm_pkg::BASE_W-1:0] BASE_MAX = '1;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 8;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_ready_o;
  fcpm_pkg::in_t                    in_i;
  logic                             out_valid_o;
  logic                             out_ready_i;
  fcpm_pkg::out_t                   out_o;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [fcpm_pkg::CFG_INDEX_W-1:0] cfg_index_i;
  logic [fcpm_pkg::CFG_DATA_W-1:0]  cfg_data_i;

  four_channel_pcm_playback_mixer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // mixer state as seen from outside
  logic [fcpm_pkg::BASE_W-1:0] clip_base [fcpm_pkg::MAX_CH] =
    '{21'h10000, 21'h20000, 21'h30000, 21'h40000};
  logic [fcpm_pkg::LEN_W-1:0]  clip_flen [fcpm_pkg::MAX_CH] =
    '{16'd14862, 16'd11598, 16'd7174, 16'd23132};
  logic [fcpm_pkg::LEN_W-1:0]  clip_ofs [fcpm_pkg::MAX_CH] = '{default: '0};
  logic                        clip_on [fcpm_pkg::MAX_CH] = '{default: 1'b0};

  fcpm_pkg::out_t mix_expect_q[$];
  int   err_cnt = 0;
  int   stall_cnt = 0;
  bit   idle_en = 1'b1;

  function automatic void flag_err(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t: %s", $time, msg);
  endfunction

  function automatic void chk_field(input string name, input logic [31:0] e,
                                    input logic [31:0] a);
    if (a !== e) flag_err($sformatf("%s expected %0h got %0h", name, e, a));
  endfunction

  function automatic fcpm_pkg::in_t mk_item(input logic [1:0] cmd, input logic [1:0] ch,
                                            input logic [31:0] smp);
    fcpm_pkg::in_t it;
    it.cmd = cmd;
    it.channel = ch;
    {it.sample_ch0, it.sample_ch1, it.sample_ch2, it.sample_ch3} = smp;
    return it;
  endfunction

  function automatic logic [fcpm_pkg::CFG_DATA_W-1:0] rand_flen(input bit long_clips);
    logic [fcpm_pkg::CFG_DATA_W-1:0] v;
    v = fcpm_pkg::CFG_DATA_W'($urandom);
    if (!long_clips) v[fcpm_pkg::LEN_W-1:0] = fcpm_pkg::LEN_W'($urandom_range(0, 80));
    else if ($urandom_range(0, 9) == 0) v[fcpm_pkg::LEN_W-1:0] = '1;
    else v[fcpm_pkg::LEN_W-1:0] = fcpm_pkg::LEN_W'($urandom_range(45, 65535));
    return v;
  endfunction

  task automatic predict_mix(input fcpm_pkg::in_t item);
    fcpm_pkg::out_t                exp;
    int                            sum;
    int                            cnt;
    int unsigned                   len;
    logic [7:0]                    smp [fcpm_pkg::MAX_CH];
    logic [fcpm_pkg::ADDR_W-1:0]   addr [fcpm_pkg::MAX_CH];
    sum = 0;
    cnt = 0;
    smp = '{item.sample_ch0, item.sample_ch1, item.sample_ch2, item.sample_ch3};
    exp = '0;
    exp.mixed_sample = fcpm_pkg::SILENCE_LEVEL;
    case (item.cmd) inside
      fcpm_pkg::CMD_START, fcpm_pkg::CMD_STOP: begin
        if (item.channel < fcpm_pkg::NUM_CHANNELS) begin
          clip_ofs[item.channel] = '0;
          clip_on[item.channel] = (item.cmd == fcpm_pkg::CMD_START);
        end
      end
      fcpm_pkg::CMD_TICK: begin
        exp.sample_valid = 1'b1;
        for (int c = 0; c < fcpm_pkg::NUM_CHANNELS; c++) begin
          if (clip_on[c]) begin
            clip_ofs[c] = clip_ofs[c] + fcpm_pkg::LEN_W'(1);
            len = (clip_flen[c] <= fcpm_pkg::HEADER_BYTES) ? 1 :
                  clip_flen[c] - fcpm_pkg::HEADER_BYTES;
            if (clip_ofs[c] >= len) begin
              clip_on[c] = 1'b0;
            end else begin
              sum += int'(smp[c]) - 128;
              cnt++;
            end
          end
        end
        if (cnt > 0) exp.mixed_sample = 8'(sum / cnt + 128);
      end
      default: ;
    endcase
    for (int c = 0; c < fcpm_pkg::MAX_CH; c++) begin
      exp.active_mask[c] = 1'b0;
      addr[c] = '0;
      if (c < fcpm_pkg::NUM_CHANNELS) begin
        exp.active_mask[c] = clip_on[c];
        addr[c] = fcpm_pkg::ADDR_W'(clip_base[c] + fcpm_pkg::HEADER_BYTES + clip_ofs[c]);
      end
    end
    exp.read_addr_ch0 = addr[0];
    exp.read_addr_ch1 = addr[1];
    exp.read_addr_ch2 = addr[2];
    exp.read_addr_ch3 = addr[3];
    mix_expect_q.push_back(exp);
  endtask

  task automatic send_item(input fcpm_pkg::in_t item);
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= item;
    do @(posedge clk_i); while (!in_ready_o);
    predict_mix(item);
  endtask

  task automatic write_reg(input logic [fcpm_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [fcpm_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < fcpm_pkg::REG_FILE_LEN_CH0) begin
      clip_base[2'(idx)] = data[fcpm_pkg::BASE_W-1:0];
    end else if (idx < REG_SPARE_FIRST) begin
      clip_flen[2'(idx - fcpm_pkg::REG_FILE_LEN_CH0)] = data[fcpm_pkg::LEN_W-1:0];
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (mix_expect_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic test_silence();
    send_item(mk_item(fcpm_pkg::CMD_TICK, 2'd0, 32'h00FF_00FF));
    send_item(mk_item(CMD_UNKNOWN, 2'd3, 32'hFFFF_FFFF));
  endtask

  task automatic test_full_mix();
    for (int c = 0; c < fcpm_pkg::MAX_CH; c++)
      send_item(mk_item(fcpm_pkg::CMD_START, 2'(c), '0));
    send_item(mk_item(fcpm_pkg::CMD_TICK, 2'd0, 32'hFFFF_FFFF));
    send_item(mk_item(fcpm_pkg::CMD_TICK, 2'd0, 32'h0000_0000));
    send_item(mk_item(fcpm_pkg::CMD_TICK, 2'd0, 32'h00FF_7F80));
    // negative sum, truncation toward zero
    send_item(mk_item(fcpm_pkg::CMD_TICK, 2'd0, 32'h0102_0380));
    send_item(mk_item(fcpm_pkg::CMD_STOP, 2'd1, '0));
    send_item(mk_item(fcpm_pkg::CMD_TICK, 2'd0, 32'h0055_FFFF));
  endtask

  task automatic test_short_clips();
    drain();
    write_reg(fcpm_pkg::REG_BASE_ADDR_CH0, '0);
    write_reg(fcpm_pkg::REG_BASE_ADDR_CH0 + 4'd1, BASE_MAX);
    write_reg(fcpm_pkg::REG_BASE_ADDR_CH0 + 4'd2, fcpm_pkg::CFG_DATA_W'($urandom));
    write_reg(fcpm_pkg::REG_BASE_ADDR_CH0 + 4'd3, 21'h15_5555);
    write_reg(fcpm_pkg::REG_FILE_LEN_CH0, '0);
    write_reg(fcpm_pkg::REG_FILE_LEN_CH0 + 4'd1,
              fcpm_pkg::CFG_DATA_W'(fcpm_pkg::HEADER_BYTES));
    write_reg(fcpm_pkg::REG_FILE_LEN_CH0 + 4'd2,
              fcpm_pkg::CFG_DATA_W'(fcpm_pkg::HEADER_BYTES + 1));
    write_reg(fcpm_pkg::REG_FILE_LEN_CH0 + 4'd3,
              fcpm_pkg::CFG_DATA_W'(fcpm_pkg::HEADER_BYTES + 3));
    for (int c = 0; c < fcpm_pkg::MAX_CH; c++)
      send_item(mk_item(fcpm_pkg::CMD_START, 2'(c), '0));
    repeat (4) send_item(mk_item(fcpm_pkg::CMD_TICK, 2'd0, $urandom()));
  endtask

  task automatic test_len_change();
    drain();
    write_reg(fcpm_pkg::REG_FILE_LEN_CH0, fcpm_pkg::CFG_DATA_W'(16'hFFFF));
    send_item(mk_item(fcpm_pkg::CMD_START, 2'd0, '0));
    repeat (3) send_item(mk_item(fcpm_pkg::CMD_TICK, 2'd0, $urandom()));
    drain();
    // offset already past the new length
    write_reg(fcpm_pkg::REG_FILE_LEN_CH0, fcpm_pkg::CFG_DATA_W'(fcpm_pkg::HEADER_BYTES + 1));
    send_item(mk_item(fcpm_pkg::CMD_TICK, 2'd0, $urandom()));
  endtask

  task automatic test_spare_regs();
    drain();
    for (int r = REG_SPARE_FIRST; r < 2 ** fcpm_pkg::CFG_INDEX_W; r++)
      write_reg(fcpm_pkg::CFG_INDEX_W'(r), fcpm_pkg::CFG_DATA_W'($urandom));
    send_item(mk_item(fcpm_pkg::CMD_START, 2'd2, $urandom()));
    send_item(mk_item(fcpm_pkg::CMD_TICK, 2'd0, $urandom()));
  endtask

  task automatic test_random_traffic(input int n_items, input bit idle, input bit long_clips);
    logic [1:0]                      cmd;
    logic [fcpm_pkg::CFG_DATA_W-1:0] base;
    int                              roll;
    drain();
    idle_en = idle;
    for (int c = 0; c < fcpm_pkg::MAX_CH; c++) begin
      roll = $urandom_range(0, 5);
      base = (roll == 0) ? '0 : (roll == 1) ? BASE_MAX : fcpm_pkg::CFG_DATA_W'($urandom);
      write_reg(fcpm_pkg::REG_BASE_ADDR_CH0 + 4'(c), base);
      write_reg(fcpm_pkg::REG_FILE_LEN_CH0 + 4'(c), rand_flen(long_clips));
    end
    for (int i = 0; i < n_items; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) cmd = fcpm_pkg::CMD_TICK;
      else if (roll < 85) cmd = fcpm_pkg::CMD_START;
      else if (roll < 95) cmd = fcpm_pkg::CMD_STOP;
      else cmd = CMD_UNKNOWN;
      send_item(mk_item(cmd, 2'($urandom_range(0, 3)), $urandom()));
      if ($urandom_range(0, 99) == 0) begin
        drain();
        write_reg(fcpm_pkg::REG_FILE_LEN_CH0 + 4'($urandom_range(0, 3)),
                  rand_flen(long_clips));
      end
    end
  endtask

  initial begin
    out_ready_i = 1'b1;
    forever begin
      @(negedge clk_i);
      if (idle_en && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : result_check
    fcpm_pkg::out_t exp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (mix_expect_q.size() == 0) begin
        flag_err($sformatf("unexpected result transfer, mixed %0h", out_o.mixed_sample));
      end else begin
        exp = mix_expect_q.pop_front();
        chk_field("mixed_sample", 32'(exp.mixed_sample), 32'(out_o.mixed_sample));
        chk_field("sample_valid", 32'(exp.sample_valid), 32'(out_o.sample_valid));
        chk_field("active_mask", 32'(exp.active_mask), 32'(out_o.active_mask));
        chk_field("read_addr_ch0", 32'(exp.read_addr_ch0), 32'(out_o.read_addr_ch0));
        chk_field("read_addr_ch1", 32'(exp.read_addr_ch1), 32'(out_o.read_addr_ch1));
        chk_field("read_addr_ch2", 32'(exp.read_addr_ch2), 32'(out_o.read_addr_ch2));
        chk_field("read_addr_ch3", 32'(exp.read_addr_ch3), 32'(out_o.read_addr_ch3));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_silence();
    test_full_mix();
    test_short_clips();
    test_len_change();
    test_spare_regs();
    for (int p = 0; p < 6; p++) test_random_traffic(215, p != 5, p == 2);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mix_expect_q.size() != 0)
      flag_err($sformatf("%0d results never arrived", mix_expect_q.size()));
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
